>>> hw/rtl/e2cal_pkg.sv
// shared constants, types and helper functions for the epoch to calendar converter
package e2cal_pkg;

    // default width of the signed seconds count
    localparam int TIME_BITS_DEF = 40;

    // width of the shared compare-subtract unit
    localparam int SUB_W = 19;

    // result field widths
    localparam int YEAR_W = 15;
    localparam int YDAY_W = 9;
    localparam int CLK_W  = 17;
    localparam int DAY_W  = 18;
    localparam int OUT_W  = 56;

    // calendar constants
    localparam int SEC_PER_DAY   = 86400;
    localparam int DAYS_PER_CYC  = 146097;
    localparam int BASE_YEAR     = 1970;
    localparam int BASE_CYC_YEAR = 370;   // 1970 mod 400
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int LAST_MONTH    = 11;

    // compare-subtract result
    typedef struct packed {
        logic             ge;
        logic [SUB_W-1:0] diff;
    } t_sub_res;

    // leap rule for a year given modulo 400
    function automatic logic leap400(input logic [8:0] c);
        logic r;
        begin
            r = (c[1:0] == 2'd0) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
            return r;
        end
    endfunction

    // add a small step to a year counted modulo 400
    function automatic logic [8:0] cyr_add(input logic [8:0] c, input logic [6:0] d);
        logic [9:0] s;
        begin
            s = {1'b0, c} + {3'b000, d};
            if (s >= 10'd400) begin
                s = s - 10'd400;
            end
            return s[8:0];
        end
    endfunction

    // weekday plus a step below 7, modulo 7
    function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [2:0] d);
        logic [3:0] s;
        begin
            s = {1'b0, w} + {1'b0, d};
            if (s >= 4'd7) begin
                s = s - 4'd7;
            end
            return s[2:0];
        end
    endfunction

    // remainder by 7 of a value below 32
    function automatic logic [2:0] mod7_5(input logic [4:0] x);
        logic [4:0] r;
        begin
            priority if (x >= 5'd28) r = x - 5'd28;
            else if (x >= 5'd21) r = x - 5'd21;
            else if (x >= 5'd14) r = x - 5'd14;
            else if (x >= 5'd7)  r = x - 5'd7;
            else                 r = x;
            return r[2:0];
        end
    endfunction

    // month lengths, month counted from 0
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] r;
        begin
            unique case (mon)
                4'd1:    r = leap ? 5'd29 : 5'd28;
                4'd3:    r = 5'd30;
                4'd5:    r = 5'd30;
                4'd8:    r = 5'd30;
                4'd10:   r = 5'd30;
                default: r = 5'd31;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/epoch_seconds_to_utc_calendar.sv
// top level: unix epoch seconds to broken-down utc calendar time
// One request in, one result out. A sequencer drives a single 19-bit compare-subtract
// unit: long division of the seconds by 86400, division of the day count by the
// 400-year cycle, steps over centuries, 4-year blocks and single years, month steps,
// and steps splitting the time of day. A negative count skips all of these steps and
// gives an error status. The input is accepted only while the sequencer is idle; a
// finished result waits in the output register and the next request may be taken
// meanwhile.
module epoch_seconds_to_utc_calendar import e2cal_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int IN_W = ((TIME_BITS + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // epoch_seconds
    input  logic [IN_W-1:0] i_s_axis_tdata,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // status, second, minute, hour, weekday, full_year, day_of_year,
    // month_number, day_of_month, zero pad
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int DW    = TIME_BITS - 1;
    localparam int DB    = TIME_BITS - 17;
    localparam int SHIFT = DW - DB;
    localparam int CNT_W = $clog2(TIME_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_DAYDIV, S_CYCDIV, S_YSET, S_YR100, S_YR4, S_YR1,
        S_MON, S_TODH, S_TODM, S_DONE
    } t_state;

    t_state              r_state;
    logic [DW-1:0]       r_num;
    logic [DAY_W-1:0]    r_rem;
    logic [CLK_W-1:0]    r_clk;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_err;
    logic [YEAR_W-1:0]   r_year;
    logic [8:0]          r_cyr;
    logic [2:0]          r_wd;
    logic [YDAY_W-1:0]   r_yday;
    logic                r_leap;
    logic [3:0]          r_mon;
    logic [4:0]          r_dom;
    logic [4:0]          r_hour;
    logic [5:0]          r_min;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_odata;

    logic [SUB_W-1:0]    w_a;
    logic [SUB_W-1:0]    w_b;
    t_sub_res            w_res;
    logic [DAY_W-1:0]    w_rem;
    logic [DW-1:0]       w_num;
    logic [8:0]          w_c2;
    logic                w_l2;
    logic                w_l1;
    logic                w_lc;
    logic [4:0]          w_mlen;
    logic [YEAR_W-1:0]   w_k;
    logic [YEAR_W-1:0]   w_year0;

    // leap flags for the stride steps
    assign w_c2   = cyr_add(r_cyr, 7'd2);
    assign w_l2   = leap400(w_c2);
    assign w_l1   = leap400(r_cyr);
    assign w_lc   = (r_cyr == 9'(BASE_CYC_YEAR));
    assign w_mlen = month_len(r_leap, r_mon);

    // first year of the 400-year cycle, 1970 + 400 * k kept to the field width
    assign w_k     = r_num[YEAR_W-1:0];
    assign w_year0 = YEAR_W'(BASE_YEAR) + (w_k << 8) + (w_k << 7) + (w_k << 4);

    // operand select for the shared unit
    always_comb begin
        w_a = {1'b0, r_rem};
        w_b = '0;
        unique case (r_state)
            S_DAYDIV: begin
                w_a = {1'b0, r_rem[CLK_W-1:0], r_num[DW-1]};
                w_b = SUB_W'(SEC_PER_DAY);
            end
            S_CYCDIV: begin
                w_a = {r_rem, r_num[DW-1]};
                w_b = SUB_W'(DAYS_PER_CYC);
            end
            S_YR100: w_b = SUB_W'(36524) + SUB_W'(w_lc);
            S_YR4:   w_b = SUB_W'(1460) + SUB_W'(w_l2);
            S_YR1:   w_b = SUB_W'(365) + SUB_W'(w_l1);
            S_MON:   w_b = SUB_W'(w_mlen);
            S_TODH: begin
                w_a = {2'b00, r_clk};
                w_b = SUB_W'(SEC_PER_HOUR) << r_cnt[2:0];
            end
            S_TODM: begin
                w_a = {2'b00, r_clk};
                w_b = SUB_W'(SEC_PER_MIN) << r_cnt[2:0];
            end
            default: begin
                w_a = {1'b0, r_rem};
                w_b = '0;
            end
        endcase
    end

    e2cal_sub u_sub (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    // division step results
    assign w_rem = w_res.ge ? w_res.diff[DAY_W-1:0] : w_a[DAY_W-1:0];
    assign w_num = {r_num[DW-2:0], w_res.ge};

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (r_ovalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_num <= i_s_axis_tdata[DW-1:0];
                        r_err <= i_s_axis_tdata[TIME_BITS-1];
                        r_rem <= '0;
                        r_cnt <= CNT_W'(DW - 1);
                        r_state <= i_s_axis_tdata[TIME_BITS-1] ? S_DONE : S_DAYDIV;
                    end
                end
                S_DAYDIV: begin
                    if (r_cnt == '0) begin
                        r_clk   <= w_rem[CLK_W-1:0];
                        r_rem   <= '0;
                        r_num   <= w_num << SHIFT;
                        r_cnt   <= CNT_W'(DB - 1);
                        r_state <= S_CYCDIV;
                    end else begin
                        r_rem <= w_rem;
                        r_num <= w_num;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_CYCDIV: begin
                    r_rem <= w_rem;
                    r_num <= w_num;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_YSET;
                    end
                end
                S_YSET: begin
                    r_year  <= w_year0;
                    r_cyr   <= 9'(BASE_CYC_YEAR);
                    r_wd    <= 3'd4;
                    r_state <= S_YR100;
                end
                // centuries starting at a year ending in 70
                S_YR100: begin
                    if (w_res.ge) begin
                        r_rem  <= w_res.diff[DAY_W-1:0];
                        r_year <= r_year + YEAR_W'(100);
                        r_cyr  <= cyr_add(r_cyr, 7'd100);
                        r_wd   <= wd_add(r_wd, w_lc ? 3'd6 : 3'd5);
                    end else begin
                        r_state <= S_YR4;
                    end
                end
                // 4-year blocks holding one multiple of four in their third year
                S_YR4: begin
                    if (w_res.ge) begin
                        r_rem  <= w_res.diff[DAY_W-1:0];
                        r_year <= r_year + YEAR_W'(4);
                        r_cyr  <= cyr_add(r_cyr, 7'd4);
                        r_wd   <= wd_add(r_wd, w_l2 ? 3'd5 : 3'd4);
                    end else begin
                        r_state <= S_YR1;
                    end
                end
                S_YR1: begin
                    if (w_res.ge) begin
                        r_rem  <= w_res.diff[DAY_W-1:0];
                        r_year <= r_year + YEAR_W'(1);
                        r_cyr  <= cyr_add(r_cyr, 7'd1);
                        r_wd   <= wd_add(r_wd, w_l1 ? 3'd2 : 3'd1);
                    end else begin
                        r_yday  <= r_rem[YDAY_W-1:0];
                        r_leap  <= w_l1;
                        r_mon   <= '0;
                        r_state <= S_MON;
                    end
                end
                S_MON: begin
                    if (w_res.ge && (r_mon != 4'(LAST_MONTH))) begin
                        r_rem <= w_res.diff[DAY_W-1:0];
                        r_mon <= r_mon + 4'd1;
                        r_wd  <= wd_add(r_wd, 3'(w_mlen - 5'd28));
                    end else begin
                        r_dom   <= r_rem[4:0] + 5'd1;
                        r_wd    <= wd_add(r_wd, mod7_5(r_rem[4:0]));
                        r_cnt   <= CNT_W'(4);
                        r_state <= S_TODH;
                    end
                end
                S_TODH: begin
                    if (w_res.ge) begin
                        r_clk <= w_res.diff[CLK_W-1:0];
                    end
                    r_hour <= {r_hour[3:0], w_res.ge};
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(5);
                        r_state <= S_TODM;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_TODM: begin
                    if (w_res.ge) begin
                        r_clk <= w_res.diff[CLK_W-1:0];
                    end
                    r_min <= {r_min[4:0], w_res.ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_err) begin
                            r_odata <= OUT_W'(1);
                        end else begin
                            r_odata <= {2'b00, r_dom, r_mon + 4'd1, r_yday, r_year,
                                        r_wd, r_hour, r_min, r_clk[5:0], 1'b0};
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

>>> hw/rtl/e2cal_sub.sv
// shared compare-subtract unit of the calendar sequencer
module e2cal_sub import e2cal_pkg::*; (
    input  logic [SUB_W-1:0] i_a,
    input  logic [SUB_W-1:0] i_b,
    output t_sub_res         o_res
);

    logic [SUB_W:0] w_d;

    // one wide subtract, borrow gives the compare
    assign w_d        = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_d[SUB_W];
    assign o_res.diff = w_d[SUB_W-1:0];

endmodule
